FILE: hdl/ccfb_pkg.sv
// ccfb_pkg: shared types and constants of the cc/cv feedback selector
// no dependencies; imported by the channel interfaces and all modules

package ccfb_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned COUNT_W  = 32;  // wrapping counter width, 8 to 32
  localparam int unsigned OUT_CNT_W = 32;

  // packet type codes
  localparam logic [ID_W-1:0] ID_CURRENT = 16'h00AA;
  localparam logic [ID_W-1:0] ID_VOLTAGE = 16'h00EA;

  // packet kind codes reported on the result word
  localparam logic [1:0] KIND_CURRENT = 2'd0;
  localparam logic [1:0] KIND_VOLTAGE = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  // smoothing coefficients, 0.98 and 0.02 in Q24
  localparam int unsigned KEEP_W = 24;
  localparam int unsigned NEW_W  = 19;
  localparam logic [KEEP_W-1:0] COEF_KEEP = 24'd16441671;
  localparam logic [NEW_W-1:0]  COEF_NEW  = 19'd335544;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_CURRENT_THR = 2'd0;
  localparam logic [1:0] REG_VOLTAGE_THR = 2'd1;
  localparam logic [1:0] REG_UPDATE_EN   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]     packet_id;
    logic [SAMPLE_W-1:0] sample_data;
  } ccfb_in_word_t;

  typedef struct packed {
    logic [1:0]           packet_kind;
    logic                 cc_mode;
    logic                 mode_changed;
    logic [SAMPLE_W-1:0]  feedback_value;
    logic [SAMPLE_W-1:0]  current_filtered;
    logic [SAMPLE_W-1:0]  voltage_filtered;
    logic                 update_request;
    logic [OUT_CNT_W-1:0] bad_packets;
    logic [OUT_CNT_W-1:0] total_packets;
  } ccfb_out_word_t;

endpackage

FILE: hdl/ccfb_channels.sv
// ccfb_channels: valid/ready channel interfaces for packet and result words
// depends on ccfb_pkg

interface ccfb_in_if
  import ccfb_pkg::*;
();
  logic          valid;
  logic          ready;
  ccfb_in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccfb_out_if
  import ccfb_pkg::*;
();
  logic           valid;
  logic           ready;
  ccfb_out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ccfb_ema.sv
// ccfb_ema: one step of the Q24 exponential filter, 0.98*old + 0.02*sample
// depends on ccfb_pkg; two parallel constant multiplies and one add

module ccfb_ema
  import ccfb_pkg::*;
(
  input  logic [SAMPLE_W-1:0] old_val,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] new_val
);

  logic [KEEP_W+SAMPLE_W-1:0] keep_prod;
  logic [NEW_W+SAMPLE_W-1:0]  new_prod;
  logic [SAMPLE_W-1:0]        keep_part;
  logic [SAMPLE_W-1:0]        new_part;

  // truncating Q24 products
  assign keep_prod = (KEEP_W+SAMPLE_W)'(COEF_KEEP) * (KEEP_W+SAMPLE_W)'(old_val);
  assign new_prod  = (NEW_W+SAMPLE_W)'(COEF_NEW) * (NEW_W+SAMPLE_W)'(sample);
  assign keep_part = keep_prod[KEEP_W+SAMPLE_W-1:SAMPLE_W];
  assign new_part  = SAMPLE_W'(new_prod[NEW_W+SAMPLE_W-1:SAMPLE_W]);

  // the sum stays below 2^24 for every input
  assign new_val = SAMPLE_W'(keep_part + new_part);

endmodule

FILE: hdl/cc_cv_feedback_selector.sv
// cc_cv_feedback_selector: cc/cv mode switch with smoothed current and voltage
// an accepted word passes the input register and then the result register
// throughput: one packet per cycle while results are taken; the state loop
//   is one pass through the two filter multiplies and an add, closed in
//   the result stage; an untaken result holds the word in the input stage
// reset (rst_n low, synchronous): cv mode, samples, filters and counters zero,
//   thresholds 0xFFFFFF, update enable 1
// depends on ccfb_pkg, ccfb_channels, ccfb_ema

module cc_cv_feedback_selector
  import ccfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ccfb_in_if.sink               in_ch,
  ccfb_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [SAMPLE_W-1:0] cur_thr_r;
  logic [SAMPLE_W-1:0] volt_thr_r;
  logic                upd_en_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  // input stage
  logic                s1_valid_r;
  ccfb_in_word_t       s1_word_r;

  // block state
  logic [SAMPLE_W-1:0] last_cur_r, last_cur_nxt;
  logic [SAMPLE_W-1:0] last_volt_r, last_volt_nxt;
  logic [SAMPLE_W-1:0] smooth_cur_r, smooth_cur_nxt;
  logic [SAMPLE_W-1:0] smooth_volt_r, smooth_volt_nxt;
  logic [SAMPLE_W-1:0] ema_cur, ema_volt;
  logic                cc_mode_r, cc_mode_nxt;
  logic [COUNT_W-1:0]  bad_cnt_r, bad_cnt_nxt;
  logic [COUNT_W-1:0]  all_cnt_r, all_cnt_nxt;
  logic                changed;
  logic                is_cur, is_volt;
  logic [1:0]          kind;

  // result stage
  logic                out_valid_r;
  ccfb_out_word_t      out_word_r, out_word_nxt;
  logic                out_free;
  logic                advance;

  // apb register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_thr_r  <= '1;
      volt_thr_r <= '1;
      upd_en_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CURRENT_THR: cur_thr_r  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_VOLTAGE_THR: volt_thr_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_UPDATE_EN:   upd_en_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (cfg_idx)
      REG_CURRENT_THR: cfg_prdata = 32'(cur_thr_r);
      REG_VOLTAGE_THR: cfg_prdata = 32'(volt_thr_r);
      REG_UPDATE_EN:   cfg_prdata = 32'(upd_en_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // pipeline flow control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_word_r <= in_ch.data;
    end
  end

  // filter steps for both channels
  ccfb_ema u_ema_cur (
    .old_val (smooth_cur_r),
    .sample  (s1_word_r.sample_data),
    .new_val (ema_cur)
  );

  ccfb_ema u_ema_volt (
    .old_val (smooth_volt_r),
    .sample  (s1_word_r.sample_data),
    .new_val (ema_volt)
  );

  // decode and state update for the word in the input stage
  assign is_cur  = (s1_word_r.packet_id == ID_CURRENT);
  assign is_volt = (s1_word_r.packet_id == ID_VOLTAGE);

  always_comb begin
    last_cur_nxt    = last_cur_r;
    last_volt_nxt   = last_volt_r;
    smooth_cur_nxt  = smooth_cur_r;
    smooth_volt_nxt = smooth_volt_r;
    cc_mode_nxt     = cc_mode_r;
    bad_cnt_nxt     = bad_cnt_r;
    changed         = 1'b0;
    kind            = KIND_UNKNOWN;
    if (is_cur) begin
      kind           = KIND_CURRENT;
      last_cur_nxt   = s1_word_r.sample_data;
      smooth_cur_nxt = ema_cur;
      if ((s1_word_r.sample_data > cur_thr_r) && !cc_mode_r) begin
        cc_mode_nxt = 1'b1;
        changed     = 1'b1;
      end
    end else if (is_volt) begin
      kind            = KIND_VOLTAGE;
      last_volt_nxt   = s1_word_r.sample_data;
      smooth_volt_nxt = ema_volt;
      if ((s1_word_r.sample_data > volt_thr_r) && cc_mode_r) begin
        cc_mode_nxt = 1'b0;
        changed     = 1'b1;
      end
    end else begin
      bad_cnt_nxt = COUNT_W'(bad_cnt_r + 1'b1);
    end
    all_cnt_nxt = COUNT_W'(all_cnt_r + 1'b1);
  end

  // result word
  always_comb begin
    out_word_nxt.packet_kind      = kind;
    out_word_nxt.cc_mode          = cc_mode_nxt;
    out_word_nxt.mode_changed     = changed;
    out_word_nxt.feedback_value   = cc_mode_nxt ? last_cur_nxt : last_volt_nxt;
    out_word_nxt.current_filtered = smooth_cur_nxt;
    out_word_nxt.voltage_filtered = smooth_volt_nxt;
    out_word_nxt.update_request   = (is_cur || is_volt) && upd_en_r;
    out_word_nxt.bad_packets      = OUT_CNT_W'(bad_cnt_nxt);
    out_word_nxt.total_packets    = OUT_CNT_W'(all_cnt_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cur_r    <= '0;
      last_volt_r   <= '0;
      smooth_cur_r  <= '0;
      smooth_volt_r <= '0;
      cc_mode_r     <= 1'b0;
      bad_cnt_r     <= '0;
      all_cnt_r     <= '0;
    end else if (advance) begin
      last_cur_r    <= last_cur_nxt;
      last_volt_r   <= last_volt_nxt;
      smooth_cur_r  <= smooth_cur_nxt;
      smooth_volt_r <= smooth_volt_nxt;
      cc_mode_r     <= cc_mode_nxt;
      bad_cnt_r     <= bad_cnt_nxt;
      all_cnt_r     <= all_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

`ifndef SYNTHESIS
  // an unknown packet neither switches the mode nor asks for an update
  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !is_cur && !is_volt |=>
      !out_word_r.mode_changed && !out_word_r.update_request)
    else $error("unknown packet changed mode or requested update");

  // the packet count moves by one per word passed to the result stage
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> all_cnt_r == COUNT_W'($past(all_cnt_r) + 1'b1))
    else $error("total packet count did not step by one");

  // mode only moves when a word is processed
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(cc_mode_r) && $stable(all_cnt_r))
    else $error("state changed without a processed word");

  // a stalled word in the input stage is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_word_r))
    else $error("input stage word lost while stalled");

  // the result word reports the registered mode
  a_out_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_word_r.cc_mode == cc_mode_r)
    else $error("result mode differs from block mode");
`endif

endmodule
